// ----- rtl/sxtok_pkg.sv -----
package sxtok_pkg;

	// Depth of the queue between the scanner and the output stage
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_STRING  = 3'd2,
		MODE_ESCAPE  = 3'd3,
		MODE_NUMBER  = 3'd4,
		MODE_SYMBOL  = 3'd5
	} mode_t;

	localparam logic [2:0] TK_OPEN   = 3'd0;
	localparam logic [2:0] TK_CLOSE  = 3'd1;
	localparam logic [2:0] TK_STRING = 3'd2;
	localparam logic [2:0] TK_NUMBER = 3'd3;
	localparam logic [2:0] TK_SYMBOL = 3'd4;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BELL      = 8'h07;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LSQUARE   = 8'h5B;
	localparam logic [7:0] CH_RSQUARE   = 8'h5D;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;

	typedef struct packed {
		logic [2:0] token_kind;
		logic       has_char;
		logic [7:0] out_char;
		logic       token_end;
		logic       bad_escape;
		logic       last;
	} item_t;

	// Up to two result items caused by one input item
	typedef struct packed {
		item_t item0;
		item_t item1;
		logic  two;
	} entry_t;

	function automatic item_t make_item(logic [2:0] k, logic has, logic [7:0] ch,
			logic e, logic bad);
		item_t it;
		it.token_kind = k;
		it.has_char   = has;
		it.out_char   = has ? ch : 8'h00;
		it.token_end  = e;
		it.bad_escape = bad;
		it.last       = 1'b0;
		return it;
	endfunction

endpackage

// ----- rtl/sxtok_front.sv -----
module sxtok_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [7:0]        text_byte,
	input  logic              q_full,
	output logic              push,
	output sxtok_pkg::entry_t push_entry
);
	import sxtok_pkg::*;

	mode_t      mode_q, mode_d;
	logic       fire;
	logic [7:0] c;
	logic       is_blank, is_digit, is_open, is_close;

	mode_t      idle_mode;
	logic       idle_emit;
	item_t      idle_item;

	logic       esc_ok;
	logic [7:0] esc_ch;

	logic       emit0, emit1;
	item_t      item0, item1;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign c        = text_byte;

	assign is_blank = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	assign is_digit = c inside {[CH_DIGIT_0:CH_DIGIT_9]};
	assign is_open  = (c == CH_LPAREN) || (c == CH_LSQUARE);
	assign is_close = (c == CH_RPAREN) || (c == CH_RSQUARE);

	// byte seen from idle: also used to rescan a terminator
	always_comb begin
		idle_mode = MODE_IDLE;
		idle_emit = 1'b0;
		idle_item = make_item(TK_OPEN, 1'b0, 8'h00, 1'b0, 1'b0);
		if (is_blank) begin
			idle_mode = MODE_IDLE;
		end else if (is_open) begin
			idle_emit = 1'b1;
			idle_item = make_item(TK_OPEN, 1'b0, 8'h00, 1'b1, 1'b0);
		end else if (is_close) begin
			idle_emit = 1'b1;
			idle_item = make_item(TK_CLOSE, 1'b0, 8'h00, 1'b1, 1'b0);
		end else if (c == CH_SEMICOLON) begin
			idle_mode = MODE_COMMENT;
		end else if (c == CH_QUOTE) begin
			idle_mode = MODE_STRING;
		end else if (is_digit) begin
			idle_mode = MODE_NUMBER;
			idle_emit = 1'b1;
			idle_item = make_item(TK_NUMBER, 1'b1, c, 1'b0, 1'b0);
		end else begin
			idle_mode = MODE_SYMBOL;
			idle_emit = 1'b1;
			idle_item = make_item(TK_SYMBOL, 1'b1, c, 1'b0, 1'b0);
		end
	end

	always_comb begin
		esc_ok = 1'b1;
		case (c)
			CH_LOWER_T:   esc_ch = CH_TAB;
			CH_LOWER_R:   esc_ch = CH_CR;
			CH_LOWER_N:   esc_ch = CH_NEWLINE;
			CH_LOWER_A:   esc_ch = CH_BELL;
			CH_BACKSLASH: esc_ch = CH_BACKSLASH;
			default: begin
				esc_ch = 8'h00;
				esc_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (fire) begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		emit0  = 1'b0;
		emit1  = 1'b0;
		item0  = make_item(TK_OPEN, 1'b0, 8'h00, 1'b0, 1'b0);
		item1  = make_item(TK_OPEN, 1'b0, 8'h00, 1'b0, 1'b0);
		if (kind) begin
			// end of input closes any open token
			mode_d = MODE_IDLE;
			case (mode_q)
				MODE_STRING, MODE_ESCAPE: begin
					emit0 = 1'b1;
					item0 = make_item(TK_STRING, 1'b0, 8'h00, 1'b1, 1'b0);
				end
				MODE_NUMBER: begin
					emit0 = 1'b1;
					item0 = make_item(TK_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0);
				end
				MODE_SYMBOL: begin
					emit0 = 1'b1;
					item0 = make_item(TK_SYMBOL, 1'b0, 8'h00, 1'b1, 1'b0);
				end
				default: begin
					emit0 = 1'b0;
				end
			endcase
		end else begin
			case (mode_q)
				MODE_COMMENT: begin
					if (c == CH_NEWLINE) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_STRING: begin
					if (c == CH_BACKSLASH) begin
						mode_d = MODE_ESCAPE;
					end else if (c == CH_QUOTE) begin
						mode_d = MODE_IDLE;
						emit0  = 1'b1;
						item0  = make_item(TK_STRING, 1'b0, 8'h00, 1'b1, 1'b0);
					end else begin
						emit0 = 1'b1;
						item0 = make_item(TK_STRING, 1'b1, c, 1'b0, 1'b0);
					end
				end
				MODE_ESCAPE: begin
					mode_d = MODE_STRING;
					emit0  = 1'b1;
					item0  = make_item(TK_STRING, esc_ok, esc_ch, 1'b0, !esc_ok);
				end
				MODE_NUMBER: begin
					emit0 = 1'b1;
					if (is_digit || c == CH_DOT) begin
						item0 = make_item(TK_NUMBER, 1'b1, c, 1'b0, 1'b0);
					end else begin
						item0  = make_item(TK_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0);
						item1  = idle_item;
						emit1  = idle_emit;
						mode_d = idle_mode;
					end
				end
				MODE_SYMBOL: begin
					emit0 = 1'b1;
					if (is_blank) begin
						item0  = make_item(TK_SYMBOL, 1'b0, 8'h00, 1'b1, 1'b0);
						mode_d = MODE_IDLE;
					end else if (is_open || is_close || c == CH_SEMICOLON) begin
						item0  = make_item(TK_SYMBOL, 1'b0, 8'h00, 1'b1, 1'b0);
						item1  = idle_item;
						emit1  = idle_emit;
						mode_d = idle_mode;
					end else begin
						item0 = make_item(TK_SYMBOL, 1'b1, c, 1'b0, 1'b0);
					end
				end
				default: begin
					// idle, and the unused codes
					emit0  = idle_emit;
					item0  = idle_item;
					mode_d = idle_mode;
				end
			endcase
		end
		item0.last = !emit1;
		item1.last = 1'b1;
	end

	assign push             = fire && emit0;
	assign push_entry.item0 = item0;
	assign push_entry.item1 = item1;
	assign push_entry.two   = emit1;

endmodule

// ----- rtl/sxtok_queue.sv -----
module sxtok_queue #(
	parameter int QUEUE_DEPTH = sxtok_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sxtok_pkg::entry_t push_entry,
	input  logic              pop,
	output sxtok_pkg::entry_t head,
	output logic              not_empty,
	output logic              full
);
	import sxtok_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sxtok_back.sv -----
module sxtok_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sxtok_pkg::entry_t head,
	input  logic              head_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output sxtok_pkg::item_t  out_item
);
	import sxtok_pkg::*;

	logic  out_valid_q;
	item_t item_q;
	logic  second_q;	// first of a pair already loaded into the output register
	logic  load;

	assign load      = !out_valid_q || out_ready;
	assign pop       = load && head_valid && (!head.two || second_q);
	assign out_valid = out_valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			item_q <= second_q ? head.item1 : head.item0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				second_q <= head.two && !second_q;
			end
		end
	end

endmodule

// ----- rtl/s_expression_tokenizer.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, text_byte
// output    out_valid / out_ready  token_kind, has_char, out_char, token_end,
//                                  bad_escape, last
//
// Takes one byte per cycle while the queue has room. A byte that causes two
// items (the end of a number or symbol followed by a rescanned terminator)
// occupies the output stage for both items in turn; the entry queue
// (QUEUE_DEPTH, default 4) absorbs these. The first item is written into the
// queue when its byte is accepted, then loaded into the output register.
// Reset: scanner idle, queue empty, no output item pending.
// in_ready drops only when the queue is full; out_ready low stalls the output
// stage alone while the scanner keeps filling the queue.
module s_expression_tokenizer #(
	parameter int QUEUE_DEPTH = sxtok_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] token_kind,
	output logic       has_char,
	output logic [7:0] out_char,
	output logic       token_end,
	output logic       bad_escape,
	output logic       last
);
	import sxtok_pkg::*;

	// scanner -> queue
	logic   push;
	entry_t push_entry;
	logic   q_full;

	// queue -> output stage
	entry_t head;
	logic   head_valid;
	logic   pop;

	item_t  out_item;

	// Front: mode register and byte classification, at most one entry per byte
	sxtok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.text_byte  (text_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Entry queue: decouples the scanner from output stalls
	sxtok_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.not_empty  (head_valid),
		.full       (q_full)
	);

	// Back: unpacks each entry into one or two output items
	sxtok_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	assign token_kind = out_item.token_kind;
	assign has_char   = out_item.has_char;
	assign out_char   = out_item.out_char;
	assign token_end  = out_item.token_end;
	assign bad_escape = out_item.bad_escape;
	assign last       = out_item.last;

	// a dropped escape is a non-final string item
	a_bad_escape_string: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_escape |-> token_kind == TK_STRING && !token_end && !has_char)
		else $error("bad_escape on a non-string or closing item");

	// no character without a token character flag
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> out_char == 8'h00)
		else $error("out_char nonzero without has_char");

	// the second item of a pair follows right after the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && last)
		else $error("second item of a pair not delivered next");

	// a character item never closes a token
	a_char_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_char |-> !token_end && !bad_escape)
		else $error("character item flagged as token end");

endmodule

// ----- bench/tb_s_expression_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_s_expression_tokenizer;
	import sxtok_pkg::*;

	// input item kinds
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	// blanks not named in the package
	localparam logic [7:0] CH_VTAB     = 8'h0B;
	localparam logic [7:0] CH_FORMFEED = 8'h0C;

	// cycles allowed after the last expected result for stray items
	localparam int TAIL_CYCLES = 20;
	// hard stop, several times the slowest legal run
	localparam int RUN_LIMIT_NS = 400_000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       kind = KIND_TEXT;
	logic [7:0] text_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] token_kind;
	logic       has_char;
	logic [7:0] out_char;
	logic       token_end;
	logic       bad_escape;
	logic       last;

	// tokenizer model state and the token items it still owes
	mode_t      lex_mode = MODE_IDLE;
	item_t      step_items[$];
	item_t      token_q[$];

	int unsigned errors = 0;
	int unsigned sent_items = 0;
	int          in_idle_pct = 30;
	int          out_idle_pct = 30;
	int          stall_req = 0;      // long output hold-off, picked up by the receiver
	int          stall_left = 0;
	string       sym_chars = "abcxyz+-*/<=>!?_:";

	s_expression_tokenizer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.text_byte  (text_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.has_char   (has_char),
		.out_char   (out_char),
		.token_end  (token_end),
		.bad_escape (bad_escape),
		.last       (last)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// Tokenizer model
	// ---------------------------------------------------------------

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
	endfunction

	function automatic item_t tok_item(logic [2:0] k, logic has, logic [7:0] ch, logic e,
			logic bad);
		item_t it;
		it.token_kind = k;
		it.has_char   = has;
		it.out_char   = has ? ch : 8'h00;
		it.token_end  = e;
		it.bad_escape = bad;
		it.last       = 1'b0;
		return it;
	endfunction

	// append one result of the current step
	function automatic void add_item(item_t it);
		step_items.insert(step_items.size(), it);
	endfunction

	// Byte seen between tokens (also the rescan after a number or symbol ends)
	function automatic void start_token(logic [7:0] c);
		if (is_blank(c)) begin
			lex_mode = MODE_IDLE;
		end else if (c == CH_LPAREN || c == CH_LSQUARE) begin
			lex_mode = MODE_IDLE;
			add_item(tok_item(TK_OPEN, 1'b0, 8'h00, 1'b1, 1'b0));
		end else if (c == CH_RPAREN || c == CH_RSQUARE) begin
			lex_mode = MODE_IDLE;
			add_item(tok_item(TK_CLOSE, 1'b0, 8'h00, 1'b1, 1'b0));
		end else if (c == CH_SEMICOLON) begin
			lex_mode = MODE_COMMENT;
		end else if (c == CH_QUOTE) begin
			lex_mode = MODE_STRING;
		end else if (is_digit(c)) begin
			lex_mode = MODE_NUMBER;
			add_item(tok_item(TK_NUMBER, 1'b1, c, 1'b0, 1'b0));
		end else begin
			lex_mode = MODE_SYMBOL;
			add_item(tok_item(TK_SYMBOL, 1'b1, c, 1'b0, 1'b0));
		end
	endfunction

	// Advance the model by one accepted input item; leaves its results in step_items
	// and appends them to token_q with last set on the final one.
	function automatic void lex_byte(logic k, logic [7:0] c);
		step_items.delete();
		if (k == KIND_EOI) begin
			// end of input closes whatever token is open; a pending escape just vanishes
			case (lex_mode)
				MODE_STRING, MODE_ESCAPE:
					add_item(tok_item(TK_STRING, 1'b0, 8'h00, 1'b1, 1'b0));
				MODE_NUMBER:
					add_item(tok_item(TK_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0));
				MODE_SYMBOL:
					add_item(tok_item(TK_SYMBOL, 1'b0, 8'h00, 1'b1, 1'b0));
				default: ;
			endcase
			lex_mode = MODE_IDLE;
		end else begin
			case (lex_mode)
				MODE_COMMENT: begin
					if (c == CH_NEWLINE)
						lex_mode = MODE_IDLE;
				end
				MODE_STRING: begin
					if (c == CH_BACKSLASH) begin
						lex_mode = MODE_ESCAPE;
					end else if (c == CH_QUOTE) begin
						add_item(tok_item(TK_STRING, 1'b0, 8'h00, 1'b1, 1'b0));
						lex_mode = MODE_IDLE;
					end else begin
						add_item(tok_item(TK_STRING, 1'b1, c, 1'b0, 1'b0));
					end
				end
				MODE_ESCAPE: begin
					case (c)
						CH_LOWER_T:   add_item(tok_item(TK_STRING, 1'b1, CH_TAB,
								1'b0, 1'b0));
						CH_LOWER_R:   add_item(tok_item(TK_STRING, 1'b1, CH_CR,
								1'b0, 1'b0));
						CH_LOWER_N:   add_item(tok_item(TK_STRING, 1'b1, CH_NEWLINE,
								1'b0, 1'b0));
						CH_LOWER_A:   add_item(tok_item(TK_STRING, 1'b1, CH_BELL,
								1'b0, 1'b0));
						CH_BACKSLASH: add_item(tok_item(TK_STRING, 1'b1,
								CH_BACKSLASH, 1'b0, 1'b0));
						// unknown escape: byte dropped, flag raised, string goes on
						default:      add_item(tok_item(TK_STRING, 1'b0, 8'h00,
								1'b0, 1'b1));
					endcase
					lex_mode = MODE_STRING;
				end
				MODE_NUMBER: begin
					if (c == CH_DOT || is_digit(c)) begin
						add_item(tok_item(TK_NUMBER, 1'b1, c, 1'b0, 1'b0));
					end else begin
						// close the number, then rescan the byte
						add_item(tok_item(TK_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0));
						start_token(c);
					end
				end
				MODE_SYMBOL: begin
					if (is_blank(c)) begin
						add_item(tok_item(TK_SYMBOL, 1'b0, 8'h00, 1'b1, 1'b0));
						lex_mode = MODE_IDLE;
					end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LSQUARE ||
							c == CH_RSQUARE || c == CH_SEMICOLON) begin
						add_item(tok_item(TK_SYMBOL, 1'b0, 8'h00, 1'b1, 1'b0));
						start_token(c);
					end else begin
						add_item(tok_item(TK_SYMBOL, 1'b1, c, 1'b0, 1'b0));
					end
				end
				// idle, plus the unreachable codes
				default: start_token(c);
			endcase
		end
		if (step_items.size() != 0)
			step_items[step_items.size() - 1].last = 1'b1;
		foreach (step_items[i])
			token_q.insert(token_q.size(), step_items[i]);
	endfunction

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------

	// Offer one item, with random idle cycles in front; model is updated on acceptance.
	// Valid stays high afterward so back-to-back items need no extra edge.
	task automatic send_byte(input logic k, input logic [7:0] c);
		while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		text_byte <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		lex_byte(k, c);
		sent_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(KIND_TEXT, s[i]);
	endtask

	// Drop valid and wait until every expected token item is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Random text pieces
	// ---------------------------------------------------------------

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(5))
			0: return CH_TAB;
			1: return CH_NEWLINE;
			2: return CH_VTAB;
			3: return CH_FORMFEED;
			4: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] pick_bracket();
		case ($urandom_range(3))
			0: return CH_LPAREN;
			1: return CH_RPAREN;
			2: return CH_LSQUARE;
			default: return CH_RSQUARE;
		endcase
	endfunction

	function automatic logic [7:0] pick_escape();
		case ($urandom_range(4))
			0: return CH_LOWER_T;
			1: return CH_LOWER_R;
			2: return CH_LOWER_N;
			3: return CH_LOWER_A;
			default: return CH_BACKSLASH;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_DIGIT_0 + 8'($urandom_range(9));
	endfunction

	// never a digit, quote, blank, bracket or semicolon
	function automatic logic [7:0] pick_symbol_char();
		if ($urandom_range(4) == 0)
			return 8'($urandom_range(128, 255));
		return sym_chars[$urandom_range(sym_chars.len() - 1)];
	endfunction

	// What follows a number or symbol: blank, bracket, comment, end of input, or nothing
	task automatic send_token_tail();
		case ($urandom_range(9))
			0, 1, 2, 3: send_byte(KIND_TEXT, pick_blank());
			4, 5:       send_byte(KIND_TEXT, pick_bracket());
			6:          send_byte(KIND_TEXT, CH_SEMICOLON);
			7:          send_byte(KIND_EOI, 8'($urandom_range(255)));
			default: ;
		endcase
	endtask

	// Mostly well-formed pieces with random content; some noise and broken ones
	task automatic send_phrase();
		int          pick;
		int          sel;
		logic [7:0]  c;
		pick = $urandom_range(99);
		if (pick < 12) begin
			send_byte(KIND_TEXT, pick_bracket());
		end else if (pick < 22) begin
			repeat ($urandom_range(1, 3))
				send_byte(KIND_TEXT, pick_blank());
		end else if (pick < 40) begin
			send_byte(KIND_TEXT, pick_digit());
			repeat ($urandom_range(5))
				send_byte(KIND_TEXT, ($urandom_range(3) == 0) ? CH_DOT : pick_digit());
			send_token_tail();
		end else if (pick < 60) begin
			send_byte(KIND_TEXT, pick_symbol_char());
			repeat ($urandom_range(5))
				send_byte(KIND_TEXT, ($urandom_range(4) == 0) ? pick_digit()
						: pick_symbol_char());
			send_token_tail();
		end else if (pick < 80) begin
			send_byte(KIND_TEXT, CH_QUOTE);
			repeat ($urandom_range(8)) begin
				sel = $urandom_range(19);
				if (sel < 14) begin
					c = 8'($urandom_range(255));
					if (c == CH_QUOTE || c == CH_BACKSLASH)
						c = CH_LOWER_A;
					send_byte(KIND_TEXT, c);
				end else if (sel < 19) begin
					send_byte(KIND_TEXT, CH_BACKSLASH);
					send_byte(KIND_TEXT, pick_escape());
				end else begin
					// anything after the backslash, mostly unknown escapes
					send_byte(KIND_TEXT, CH_BACKSLASH);
					send_byte(KIND_TEXT, 8'($urandom_range(255)));
				end
			end
			// now and then the string is left open
			if ($urandom_range(19) != 0)
				send_byte(KIND_TEXT, CH_QUOTE);
		end else if (pick < 88) begin
			send_byte(KIND_TEXT, CH_SEMICOLON);
			repeat ($urandom_range(6))
				send_byte(KIND_TEXT, 8'($urandom_range(255)));
			if ($urandom_range(9) != 0)
				send_byte(KIND_TEXT, CH_NEWLINE);
		end else if (pick < 93) begin
			send_byte(KIND_EOI, 8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 3))
				send_byte(KIND_TEXT, 8'($urandom_range(255)));
		end
	endtask

	// ---------------------------------------------------------------
	// Receiver side and result check
	// ---------------------------------------------------------------

	// Random ready, or a long hold-off when a test asks for one
	always @(posedge clk) begin
		if (stall_req != 0) begin
			stall_left = stall_req;
			stall_req  = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input int unsigned want_val,
			input int unsigned got_val);
		errors++;
		$display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want_val, got_val,
				$time);
	endtask

	always @(posedge clk) begin : check_results
		item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (token_q.size() == 0) begin
				report_mismatch("item with none expected, token_kind", 0, 32'(token_kind));
			end else begin
				want = token_q.pop_front();
				if (token_kind !== want.token_kind)
					report_mismatch("token_kind", 32'(want.token_kind), 32'(token_kind));
				if (has_char !== want.has_char)
					report_mismatch("has_char", 32'(want.has_char), 32'(has_char));
				if (out_char !== want.out_char)
					report_mismatch("out_char", 32'(want.out_char), 32'(out_char));
				if (token_end !== want.token_end)
					report_mismatch("token_end", 32'(want.token_end), 32'(token_end));
				if (bad_escape !== want.bad_escape)
					report_mismatch("bad_escape", 32'(want.bad_escape), 32'(bad_escape));
				if (last !== want.last)
					report_mismatch("last", 32'(want.last), 32'(last));
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// all four bracket bytes
	task automatic test_brackets();
		send_text("([)]");
	endtask

	// number with dot, ended by a letter that starts a symbol; high byte in the
	// symbol; bracket ends the symbol and is rescanned as a close
	task automatic test_number_end();
		send_text("1.9a");
		send_byte(KIND_TEXT, 8'hFF);
		send_text("]");
	endtask

	// tab escape, quote after backslash (unknown), close, then an empty string
	task automatic test_strings();
		send_text("\"\\t\\\"\"\"\"");
	endtask

	// comment holding a zero byte, newline ends it; vertical tab ends a symbol;
	// space ends a number
	task automatic test_comments_blanks();
		send_text(";");
		send_byte(KIND_TEXT, 8'h00);
		send_text("\nx");
		send_byte(KIND_TEXT, CH_VTAB);
		send_text("5 ");
	endtask

	// end of input inside an escape, a number, a comment, a symbol, and when idle
	task automatic test_end_of_input();
		send_text("\"\\");
		send_byte(KIND_EOI, 8'h00);
		send_text("7");
		send_byte(KIND_EOI, 8'hA5);
		send_text(";");
		send_byte(KIND_EOI, 8'h5A);
		send_text("q");
		send_byte(KIND_EOI, 8'hFF);
		send_byte(KIND_EOI, 8'h00);
		drain();
	endtask

	// Output held off for a long time while input keeps coming: the entry queue
	// fills and in_ready must drop; then the sender waits for everything.
	task automatic test_output_stall();
		int unsigned start;
		in_idle_pct = 0;
		stall_req   = 80;
		start       = sent_items;
		while (sent_items - start < 40)
			send_phrase();
		drain();
		in_idle_pct = 30;
	endtask

	task automatic test_random_stream(input int unsigned target, input int in_pct,
			input int out_pct);
		int unsigned start;
		in_idle_pct  = in_pct;
		out_idle_pct = out_pct;
		start        = sent_items;
		while (sent_items - start < target)
			send_phrase();
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_brackets();
		test_number_end();
		test_strings();
		test_comments_blanks();
		test_end_of_input();
		test_output_stall();
		// idles on both sides, then a long stretch with none
		test_random_stream(800, 30, 30);
		test_random_stream(420, 0, 0);

		// catch any stray items after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && token_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
